// File: hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache: result codes,
// operation codes and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package lkv_pkg;

    // Field widths fixed by the item format
    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    // Result codes
    typedef enum logic [STAT_W-1:0] {
        STAT_FOUND = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_ERROR = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the item and its key compare
        logic execute;   // apply lookup, update ages and storage
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_resp; // current item produces a result
    } dp_status_t;

endpackage

// File: hdl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for the cache: idle, execute, and a one-cycle result slot for
// items that produce a result.
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lkv_pkg::dp_status_t stat,
    output lkv_pkg::ctrl_cmd_t  ctrl,
    output logic               busy,
    output logic               done
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.need_resp ? S_RESP : S_IDLE;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands and handshake
    assign ctrl.capture = (state_reg == S_IDLE) && start;
    assign ctrl.execute = (state_reg == S_EXEC);
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_RESP);

endmodule

// File: hdl/lkv_dpath.sv
// ----------------------------------------------------------------------------
// lkv_dpath
// Key store with parallel compare, per-entry recency ranks, data memory
// and the capacity register.
// ----------------------------------------------------------------------------
module lkv_dpath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkv_pkg::ctrl_cmd_t          ctrl,
    output lkv_pkg::dp_status_t         stat,
    input  logic                        cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        cmd,
    input  logic signed [lkv_pkg::WORD_W-1:0] key,
    input  logic signed [lkv_pkg::WORD_W-1:0] data,
    output logic [lkv_pkg::STAT_W-1:0]  status,
    output logic signed [lkv_pkg::WORD_W-1:0] value
);
    import lkv_pkg::*;

    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int CMW = (CW > CAP_W) ? CW : CAP_W;

    // Configuration
    logic [CAP_W-1:0]  capacity_reg;

    // Entry state
    logic [WORD_W-1:0] key_reg   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]     age_reg   [MAX_ENTRIES];
    logic [IW-1:0]     age_next  [MAX_ENTRIES];
    logic [CW-1:0]     fill_reg, fill_next;
    logic [WORD_W-1:0] data_mem  [MAX_ENTRIES];

    // Captured item
    logic              cmd_reg;
    logic [WORD_W-1:0] key_in_reg;
    logic [WORD_W-1:0] data_in_reg;
    logic [MAX_ENTRIES-1:0] hit_vec_reg;

    // Result
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] rd_data_reg;

    // Execute-cycle decisions
    logic              cap_zero;
    logic              fill_lt_cap;
    logic              hit_any;
    logic [IW-1:0]     hit_idx;
    logic [IW-1:0]     hit_age;
    logic [IW-1:0]     oldest_age;
    logic [IW-1:0]     victim_idx;
    logic [IW-1:0]     tgt_idx;
    logic [IW-1:0]     tgt_lim;
    logic              age_all;
    logic              do_touch;
    logic              key_we;
    logic              mem_we;
    logic              mem_re;

    assign cap_zero    = (capacity_reg == '0);
    assign fill_lt_cap = (CMW'(fill_reg) < CMW'(capacity_reg)) &&
                         (fill_reg != CW'(MAX_ENTRIES));
    assign stat.need_resp = (cmd_reg == CMD_GET) || cap_zero;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Item capture with parallel key compare
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg     <= cmd;
            key_in_reg  <= key;
            data_in_reg <= data;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                hit_vec_reg[i] <= valid_reg[i] && (key_reg[i] == key);
            end
        end
    end

    // Hit index and rank; the oldest valid entry holds rank fill-1
    assign oldest_age = IW'(fill_reg - CW'(1));

    always_comb
    begin
        hit_idx    = '0;
        hit_age    = '0;
        victim_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = hit_idx | IW'(i);
                hit_age = hit_age | age_reg[i];
            end
            if (valid_reg[i] && (age_reg[i] == oldest_age))
            begin
                victim_idx = victim_idx | IW'(i);
            end
        end
    end

    assign hit_any = |hit_vec_reg;

    // Execute: choose the target entry and the kind of update
    always_comb
    begin
        tgt_idx     = hit_idx;
        tgt_lim     = hit_age;
        age_all     = 1'b0;
        do_touch    = 1'b0;
        key_we      = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        valid_next  = valid_reg;
        fill_next   = fill_reg;
        status_next = status_reg;
        if (ctrl.execute)
        begin
            if (cap_zero)
            begin
                status_next = (cmd_reg == CMD_GET) ? STAT_MISS : STAT_ERROR;
            end
            else if (cmd_reg == CMD_GET)
            begin
                if (hit_any)
                begin
                    do_touch    = 1'b1;
                    mem_re      = 1'b1;
                    status_next = STAT_FOUND;
                end
                else
                begin
                    status_next = STAT_MISS;
                end
            end
            else if (hit_any)
            begin
                // update existing key
                do_touch = 1'b1;
                mem_we   = 1'b1;
            end
            else if (fill_lt_cap)
            begin
                // valid entries always occupy the low indexes
                tgt_idx             = fill_reg[IW-1:0];
                age_all             = 1'b1;
                do_touch            = 1'b1;
                key_we              = 1'b1;
                mem_we              = 1'b1;
                valid_next[tgt_idx] = 1'b1;
                fill_next           = fill_reg + CW'(1);
            end
            else
            begin
                // evict least recently used
                tgt_idx  = victim_idx;
                age_all  = 1'b1;
                do_touch = 1'b1;
                key_we   = 1'b1;
                mem_we   = 1'b1;
            end
        end
    end

    // Recency update: target becomes 0, younger valid entries age by one
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (do_touch)
            begin
                if (IW'(i) == tgt_idx)
                begin
                    age_next[i] = '0;
                end
                else if (valid_reg[i] && (age_all || (age_reg[i] < tgt_lim)))
                begin
                    age_next[i] = IW'(age_reg[i] + 1'b1);
                end
            end
        end
    end

    // Control state of the entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            status_reg <= STAT_MISS;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            fill_reg   <= fill_next;
            status_reg <= status_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // Key store
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_reg[tgt_idx] <= key_in_reg;
        end
    end

    // Data memory, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[tgt_idx] <= data_in_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= data_mem[tgt_idx];
        end
    end

    // Result fields
    assign status = status_reg;
    assign value  = (status_reg == STAT_FOUND) ? rd_data_reg : '0;

endmodule

// File: hdl/lru_key_value_cache.sv
// Result: a get result (or zero-capacity put error) is strobed on done in the
//   result state, entered from the execute state that the accepting edge starts.
// Items: a new item is accepted only while idle, after the key compare, the
//   update in the execute state and, for a get or error put, the result state.
// Reset: all entries invalid, capacity 16; no clearing pass. The receiver
//   cannot stall, so done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with LRU replacement and run-time capacity.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic signed [lkv_pkg::WORD_W-1:0]  key,
    input  logic signed [lkv_pkg::WORD_W-1:0]  data,
    output logic                               done,
    output logic [lkv_pkg::STAT_W-1:0]         status,
    output logic signed [lkv_pkg::WORD_W-1:0]  value,
    input  logic                               cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]          cfg_wdata
);
    import lkv_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t stat;

    // Sequencer
    lkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // Storage and lookup
    lkv_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .key       (key),
        .data      (data),
        .status    (status),
        .value     (value)
    );

endmodule

// File: hdl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks on the cache handshake and result timing.
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [lkv_pkg::STAT_W-1:0]        status,
    input logic signed [lkv_pkg::WORD_W-1:0] value
);
    import lkv_pkg::*;

    // A result only appears while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Accepted item holds busy and gives no result in the next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accept did not start work");

    // Value is zero unless found
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_FOUND)) |-> (value == '0))
        else $error("nonzero value without found status");

    // Only defined result codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == STAT_FOUND) || (status == STAT_MISS) ||
                  (status == STAT_ERROR)))
        else $error("undefined status code");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .value  (value)
);
